FILE: src/linear_blend_vertex_skinning_core_defines.svh
// Assertion macros shared by the skinning core RTL.
`ifndef LINEAR_BLEND_VERTEX_SKINNING_CORE_DEFINES_SVH
`define LINEAR_BLEND_VERTEX_SKINNING_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LBVS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LBVS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LBVS_ASSERT(lbl, clk, rst_n, prop, msg)
`define LBVS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: src/lbvs_pkg.sv
`default_nettype none
package lbvs_pkg;

  localparam int unsigned VERTEX_DEPTH_DEF = 4096;
  localparam int unsigned DATA_W           = 32;
  localparam int unsigned IDX_W            = 12;
  localparam int unsigned CNT_W            = 13;
  localparam int unsigned WGT_W            = 17;
  localparam int unsigned PADDR_W          = 3;

  // Register index as seen in paddr[2].
  localparam logic REG_VERTEX_COUNT = 1'b0;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_MATRIX = 2'd1,
    REQ_WEIGHT = 2'd2,
    REQ_READ   = 2'd3
  } req_type_e;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [IDX_W-1:0]         vertex_index;
    logic [1:0]               matrix_row;
    logic signed [DATA_W-1:0] val0;
    logic signed [DATA_W-1:0] val1;
    logic signed [DATA_W-1:0] val2;
    logic signed [DATA_W-1:0] val3;
    logic signed [DATA_W-1:0] norm_x;
    logic signed [DATA_W-1:0] norm_y;
    logic signed [DATA_W-1:0] norm_z;
    logic [WGT_W-1:0]         weight;
  } req_t;

  typedef struct packed {
    logic                     status;
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] pos_z;
    logic signed [DATA_W-1:0] nrm_x;
    logic signed [DATA_W-1:0] nrm_y;
    logic signed [DATA_W-1:0] nrm_z;
  } rsp_t;

endpackage
`default_nettype wire

FILE: src/lbvs_req_if.sv
`default_nettype none
interface lbvs_req_if;
  import lbvs_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/lbvs_rsp_if.sv
`default_nettype none
interface lbvs_rsp_if;
  import lbvs_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/lbvs_ram.sv
`default_nettype none
module lbvs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  output logic [WIDTH-1:0]                              rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

FILE: src/linear_blend_vertex_skinning_core.sv
// Channel  Dir  Handshake     Word
// req_i    in   valid/ready   lbvs_pkg::req_t (one request)
// rsp_o    out  valid/ready   lbvs_pkg::rsp_t (one result per request)
// apb      in   psel/penable  vertex_count at byte address 0
//
// One request at a time; one shared 33x33 multiplier does every product.
// Matrix and ignored requests go straight to the output state, a load writes
// first; a weight runs six passes of six multiplier steps, a read a sqrt of 32
// steps, then three restoring divisions. A full output register holds a
// finished word, so the core waits in its output state until it drains.
// Reset clears the bone matrix and vertex_count; the vertex RAMs need no clear.
`default_nettype none
`include "linear_blend_vertex_skinning_core_defines.svh"
module linear_blend_vertex_skinning_core #(
  parameter int unsigned VERTEX_DEPTH = lbvs_pkg::VERTEX_DEPTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  lbvs_req_if.sink                          req_i,
  lbvs_rsp_if.source                        rsp_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [lbvs_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import lbvs_pkg::*;

  localparam int unsigned AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
  localparam int unsigned RW = 6 * DATA_W;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_LOAD = 10'b0000000010,
    ST_RD   = 10'b0000000100,
    ST_LAT  = 10'b0000001000,
    ST_WGT  = 10'b0000010000,
    ST_WB   = 10'b0000100000,
    ST_SQ   = 10'b0001000000,
    ST_SQRT = 10'b0010000000,
    ST_DIV  = 10'b0100000000,
    ST_OUT  = 10'b1000000000
  } state_e;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] y;
    if (x > 66'sd2147483647) begin
      y = 32'sh7fffffff;
    end else if (x < -66'sd2147483648) begin
      y = 32'sh80000000;
    end else begin
      y = x[31:0];
    end
    return y;
  endfunction

  function automatic logic signed [31:0] pick3(input logic signed [31:0] a0,
                                               input logic signed [31:0] a1,
                                               input logic signed [31:0] a2,
                                               input logic [1:0] s);
    logic signed [31:0] y;
    unique case (s)
      2'd0: y = a0;
      2'd1: y = a1;
      2'd2: y = a2;
      default: y = '0;
    endcase
    return y;
  endfunction

  state_e state_q, state_d;
  logic [CNT_W-1:0] vcount_q;
  logic signed [31:0] mat_q [12];

  logic [1:0]        type_q;
  logic [IDX_W-1:0]  idx_q;
  logic [WGT_W-1:0]  w_q;
  logic              status_q;
  logic signed [31:0] vin_q [3];
  logic signed [31:0] nin_q [3];
  logic signed [31:0] rp_q [3];
  logic signed [31:0] rn_q [3];
  logic signed [31:0] sp_q [3];
  logic signed [31:0] sn_q [3];
  logic signed [31:0] nrm_q [3];

  logic [2:0]  task_q;
  logic [2:0]  sub_q;
  logic [5:0]  dcnt_q;
  logic signed [63:0] prod_q;
  logic signed [65:0] acc_q;
  logic [63:0] rem_q, root_q, bit_q;
  logic [47:0] dnum_q;
  logic [31:0] drem_q;
  logic        neg_q;

  logic rsp_valid_q, rsp_valid_d;
  rsp_t rsp_data_q, rsp_data_d;

  logic req_fire, idx_ok, out_load, is_rd, kind;
  logic [1:0] r_sel, col;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_full;
  logic signed [31:0] pt, tgt, sum_new, dsrc;
  logic signed [63:0] psh;
  logic signed [33:0] sumv;
  logic [63:0] sq_t;
  logic        sq_ge;
  logic [32:0] rs, rs_sub;
  logic        d_ge;
  logic [31:0] dmag;

  logic [AW-1:0] ram_addr;
  logic          rest_we, sum_we;
  logic [RW-1:0] rest_wdata, sum_wdata, rest_rdata, sum_rdata;

  // APB register.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? {{(32-CNT_W){1'b0}}, vcount_q} : '0;

  assign req_fire = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);
  assign idx_ok = ({1'b0, req_i.data.vertex_index} < vcount_q) &&
                  (32'(req_i.data.vertex_index) < VERTEX_DEPTH);

  assign r_sel = task_q[2:1];
  assign kind  = task_q[0];
  assign col   = sub_q[1:0];

  // Saturated transformed component, valid once the three products are summed.
  assign pt = sat32(acc_q >>> 16);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    dsrc  = '0;
    if (state_q == ST_WGT) begin
      if (sub_q == 3'd4) begin
        mul_a = {pt[31], pt};
        mul_b = {16'b0, w_q};
      end else begin
        mul_a = {mat_q[{r_sel, col}][31], mat_q[{r_sel, col}]};
        dsrc  = kind ? pick3(rn_q[0], rn_q[1], rn_q[2], col)
                     : pick3(rp_q[0], rp_q[1], rp_q[2], col);
        mul_b = {dsrc[31], dsrc};
      end
    end else begin
      // The divider works on one normal component per pass.
      dsrc  = pick3(sn_q[0], sn_q[1], sn_q[2], (state_q == ST_DIV) ? task_q[1:0] : col);
      mul_a = {dsrc[31], dsrc};
      mul_b = {dsrc[31], dsrc};
    end
  end

  assign prod_full = mul_a * mul_b;

  assign tgt = kind ? pick3(sn_q[0], sn_q[1], sn_q[2], r_sel)
                    : pick3(sp_q[0], sp_q[1], sp_q[2], r_sel);
  assign psh     = prod_q >>> 16;
  assign sumv    = 34'(tgt) + psh[33:0];
  assign sum_new = sat32(66'(sumv));

  assign sq_t  = root_q + bit_q;
  assign sq_ge = rem_q >= sq_t;

  assign rs     = {drem_q, dnum_q[47]};
  assign rs_sub = rs - {1'b0, root_q[31:0]};
  assign d_ge   = rs >= {1'b0, root_q[31:0]};
  assign dmag   = dsrc[31] ? 32'(-dsrc) : dsrc;

  assign is_rd    = (type_q == REQ_READ) && !status_q;
  assign out_load = (state_q == ST_OUT) && (!rsp_valid_q || rsp_o.ready);

  // Vertex stores: rest data and running sums, each {normal, position}.
  assign ram_addr   = AW'(idx_q);
  assign rest_we    = (state_q == ST_LOAD);
  assign rest_wdata = {nin_q[2], nin_q[1], nin_q[0], vin_q[2], vin_q[1], vin_q[0]};
  assign sum_we     = (state_q == ST_LOAD) || (state_q == ST_WB);
  assign sum_wdata  = (state_q == ST_LOAD) ? '0 :
                      {sn_q[2], sn_q[1], sn_q[0], sp_q[2], sp_q[1], sp_q[0]};

  lbvs_ram #(.WIDTH(RW), .DEPTH(VERTEX_DEPTH)) u_rest_ram (
    .clk_i   (clk_i),
    .we_i    (rest_we),
    .addr_i  (ram_addr),
    .wdata_i (rest_wdata),
    .rdata_o (rest_rdata)
  );

  lbvs_ram #(.WIDTH(RW), .DEPTH(VERTEX_DEPTH)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .addr_i  (ram_addr),
    .wdata_i (sum_wdata),
    .rdata_o (sum_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          if (req_i.data.req_type == REQ_MATRIX || !idx_ok) begin
            state_d = ST_OUT;
          end else if (req_i.data.req_type == REQ_LOAD) begin
            state_d = ST_LOAD;
          end else begin
            state_d = ST_RD;
          end
        end
      end
      ST_LOAD: state_d = ST_OUT;
      ST_RD:   state_d = ST_LAT;
      ST_LAT:  state_d = (type_q == REQ_WEIGHT) ? ST_WGT : ST_SQ;
      ST_WGT: begin
        if (sub_q == 3'd5 && task_q == 3'd5) begin
          state_d = ST_WB;
        end
      end
      ST_WB:   state_d = ST_OUT;
      ST_SQ: begin
        if (sub_q == 3'd4) begin
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (bit_q[0]) begin
          // A zero length leaves the normal fields at zero.
          state_d = ((root_q >> 1) + bit_q == 64'd0 && !sq_ge) ? ST_OUT :
                    ((sq_ge || root_q > 64'd1) ? ST_DIV : ST_OUT);
        end
      end
      ST_DIV: begin
        if (dcnt_q == 6'd49 && task_q == 3'd2) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    rsp_data_d        = rsp_data_q;
    rsp_valid_d       = rsp_valid_q;
    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
    if (out_load) begin
      rsp_valid_d       = 1'b1;
      rsp_data_d.status = status_q;
      rsp_data_d.pos_x  = is_rd ? sp_q[0] : '0;
      rsp_data_d.pos_y  = is_rd ? sp_q[1] : '0;
      rsp_data_d.pos_z  = is_rd ? sp_q[2] : '0;
      rsp_data_d.nrm_x  = is_rd ? nrm_q[0] : '0;
      rsp_data_d.nrm_y  = is_rd ? nrm_q[1] : '0;
      rsp_data_d.nrm_z  = is_rd ? nrm_q[2] : '0;
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_data_q;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vcount_q    <= '0;
      rsp_valid_q <= 1'b0;
      task_q      <= '0;
      sub_q       <= '0;
      dcnt_q      <= '0;
      for (int i = 0; i < 12; i++) begin
        mat_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      if (psel && penable && pwrite && paddr[2] == REG_VERTEX_COUNT) begin
        vcount_q <= pwdata[CNT_W-1:0];
      end
      if (req_fire && req_i.data.req_type == REQ_MATRIX && req_i.data.matrix_row != 2'd3) begin
        mat_q[{req_i.data.matrix_row, 2'd0}] <= req_i.data.val0;
        mat_q[{req_i.data.matrix_row, 2'd1}] <= req_i.data.val1;
        mat_q[{req_i.data.matrix_row, 2'd2}] <= req_i.data.val2;
        mat_q[{req_i.data.matrix_row, 2'd3}] <= req_i.data.val3;
      end
      unique case (state_q)
        ST_LAT: begin
          task_q <= '0;
          sub_q  <= '0;
        end
        ST_WGT: begin
          if (sub_q == 3'd5) begin
            sub_q  <= '0;
            task_q <= task_q + 3'd1;
          end else begin
            sub_q <= sub_q + 3'd1;
          end
        end
        ST_SQ: begin
          sub_q  <= (sub_q == 3'd4) ? 3'd0 : sub_q + 3'd1;
          task_q <= '0;
          dcnt_q <= '0;
        end
        ST_DIV: begin
          if (dcnt_q == 6'd49) begin
            dcnt_q <= '0;
            task_q <= task_q + 3'd1;
          end else begin
            dcnt_q <= dcnt_q + 6'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_full[63:0];
    if (req_fire) begin
      type_q   <= req_i.data.req_type;
      idx_q    <= req_i.data.vertex_index;
      status_q <= (req_i.data.req_type != REQ_MATRIX) && !idx_ok;
      w_q      <= (req_i.data.weight > 17'd65536) ? 17'd65536 : req_i.data.weight;
      vin_q[0] <= req_i.data.val0;
      vin_q[1] <= req_i.data.val1;
      vin_q[2] <= req_i.data.val2;
      nin_q[0] <= req_i.data.norm_x;
      nin_q[1] <= req_i.data.norm_y;
      nin_q[2] <= req_i.data.norm_z;
    end
    unique case (state_q)
      ST_LAT: begin
        for (int i = 0; i < 3; i++) begin
          rp_q[i]  <= rest_rdata[32*i +: 32];
          rn_q[i]  <= rest_rdata[96 + 32*i +: 32];
          sp_q[i]  <= sum_rdata[32*i +: 32];
          sn_q[i]  <= sum_rdata[96 + 32*i +: 32];
          nrm_q[i] <= '0;
        end
      end
      ST_WGT: begin
        unique case (sub_q)
          3'd0: acc_q <= kind ? 66'sd0 : (66'(mat_q[{r_sel, 2'd3}]) <<< 16);
          3'd1, 3'd2, 3'd3: acc_q <= acc_q + prod_q;
          3'd5: begin
            if (kind) begin
              sn_q[r_sel] <= sum_new;
            end else begin
              sp_q[r_sel] <= sum_new;
            end
          end
          default: ;
        endcase
      end
      ST_SQ: begin
        unique case (sub_q)
          3'd0: acc_q <= '0;
          3'd1, 3'd2, 3'd3: acc_q <= acc_q + prod_q;
          default: begin
            rem_q  <= acc_q[63:0];
            root_q <= '0;
            bit_q  <= 64'h4000_0000_0000_0000;
          end
        endcase
      end
      ST_SQRT: begin
        // One result bit per cycle, two radicand bits consumed.
        if (sq_ge) begin
          rem_q  <= rem_q - sq_t;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      ST_DIV: begin
        if (dcnt_q == 6'd0) begin
          dnum_q <= {dmag, 16'b0};
          drem_q <= '0;
          neg_q  <= dsrc[31];
        end else if (dcnt_q == 6'd49) begin
          nrm_q[task_q[1:0]] <= neg_q ? -$signed(dnum_q[31:0]) : $signed(dnum_q[31:0]);
        end else begin
          drem_q <= d_ge ? rs_sub[31:0] : rs[31:0];
          dnum_q <= {dnum_q[46:0], d_ge};
        end
      end
      default: ;
    endcase
    rsp_data_q <= rsp_data_d;
  end

  `LBVS_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, req_fire, !req_i.ready, "core took a second word while busy")
  `LBVS_ASSERT(a_ignored_is_zero, clk_i, rst_ni, (rsp_valid_q && rsp_data_q.status) |-> (rsp_data_q.pos_x == 32'sd0 && rsp_data_q.nrm_z == 32'sd0), "ignored request returned data")
  `LBVS_ASSERT(a_nrm_bounded, clk_i, rst_ni, rsp_valid_q |-> (rsp_data_q.nrm_x <= 32'sd65536 && rsp_data_q.nrm_x >= -32'sd65536 && rsp_data_q.nrm_y <= 32'sd65536 && rsp_data_q.nrm_y >= -32'sd65536), "normal component exceeds unit length")
  `LBVS_ASSERT(a_div_nonzero, clk_i, rst_ni, (state_q == ST_DIV) |-> (root_q != 64'd0), "division by a zero length")
endmodule
`default_nettype wire

FILE: tb/sv/linear_blend_vertex_skinning_core_test.sv
`default_nettype none
module linear_blend_vertex_skinning_core_test;
  import lbvs_pkg::*;

  // Skinning predictor plus the queue of results still owed by the core.
  class skin_scoreboard;
    longint rest_pos [VERTEX_DEPTH_DEF][3];
    longint rest_nrm [VERTEX_DEPTH_DEF][3];
    longint acc_pos [VERTEX_DEPTH_DEF][3];
    longint acc_nrm [VERTEX_DEPTH_DEF][3];
    longint bone [12];
    int unsigned vertex_count;
    rsp_t owed [$];
    int errors;
    int checked;

    function void reset_state();
      foreach (bone[i]) bone[i] = 0;
      vertex_count = 0;
      owed.delete();
      errors = 0;
      checked = 0;
    endfunction

    function longint clamp32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    function longint unsigned floor_sqrt(longint unsigned x);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= x) root = trial;
      end
      return root;
    endfunction

    function void note(req_t r);
      longint v [4];
      longint nr [3];
      longint w;
      longint pt;
      longint nt;
      longint unsigned sq;
      longint unsigned len;
      logic signed [127:0] sum_p;
      logic signed [127:0] sum_n;
      logic signed [127:0] prod;
      rsp_t e;
      int idx;
      e = '0;
      v[0] = r.val0; v[1] = r.val1; v[2] = r.val2; v[3] = r.val3;
      nr[0] = r.norm_x; nr[1] = r.norm_y; nr[2] = r.norm_z;
      w = (r.weight > 17'd65536) ? 65536 : longint'(r.weight);
      idx = int'(r.vertex_index);
      if (r.req_type == REQ_MATRIX) begin
        if (r.matrix_row < 3)
          for (int i = 0; i < 4; i++) bone[r.matrix_row * 4 + i] = v[i];
      end else if (idx >= vertex_count) begin
        e.status = 1'b1;
      end else if (r.req_type == REQ_LOAD) begin
        for (int i = 0; i < 3; i++) begin
          rest_pos[idx][i] = v[i];
          rest_nrm[idx][i] = nr[i];
          acc_pos[idx][i] = 0;
          acc_nrm[idx][i] = 0;
        end
      end else if (r.req_type == REQ_WEIGHT) begin
        for (int row = 0; row < 3; row++) begin
          sum_p = bone[row * 4 + 3];
          sum_p = sum_p <<< 16;
          sum_n = 0;
          for (int i = 0; i < 3; i++) begin
            prod = bone[row * 4 + i] * rest_pos[idx][i];
            sum_p = sum_p + prod;
            prod = bone[row * 4 + i] * rest_nrm[idx][i];
            sum_n = sum_n + prod;
          end
          pt = clamp32(longint'(sum_p >>> 16));
          nt = clamp32(longint'(sum_n >>> 16));
          acc_pos[idx][row] = clamp32(acc_pos[idx][row] + ((pt * w) >>> 16));
          acc_nrm[idx][row] = clamp32(acc_nrm[idx][row] + ((nt * w) >>> 16));
        end
      end else begin
        sq = 0;
        for (int i = 0; i < 3; i++) sq += longint'(acc_nrm[idx][i] * acc_nrm[idx][i]);
        len = floor_sqrt(sq);
        e.pos_x = 32'(acc_pos[idx][0]);
        e.pos_y = 32'(acc_pos[idx][1]);
        e.pos_z = 32'(acc_pos[idx][2]);
        if (len != 0) begin
          e.nrm_x = 32'((acc_nrm[idx][0] * 65536) / longint'(len));
          e.nrm_y = 32'((acc_nrm[idx][1] * 65536) / longint'(len));
          e.nrm_z = 32'((acc_nrm[idx][2] * 65536) / longint'(len));
        end
      end
      owed.push_back(e);
    endfunction

    function void check(rsp_t got);
      rsp_t e;
      if (owed.size() == 0) begin
        $error("result word with none expected: %h", got);
        errors++;
        return;
      end
      e = owed.pop_front();
      checked++;
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status); errors++;
      end
      if (got.pos_x !== e.pos_x) begin
        $error("pos_x: expected %0d, got %0d", e.pos_x, got.pos_x); errors++;
      end
      if (got.pos_y !== e.pos_y) begin
        $error("pos_y: expected %0d, got %0d", e.pos_y, got.pos_y); errors++;
      end
      if (got.pos_z !== e.pos_z) begin
        $error("pos_z: expected %0d, got %0d", e.pos_z, got.pos_z); errors++;
      end
      if (got.nrm_x !== e.nrm_x) begin
        $error("nrm_x: expected %0d, got %0d", e.nrm_x, got.nrm_x); errors++;
      end
      if (got.nrm_y !== e.nrm_y) begin
        $error("nrm_y: expected %0d, got %0d", e.nrm_y, got.nrm_y); errors++;
      end
      if (got.nrm_z !== e.nrm_z) begin
        $error("nrm_z: expected %0d, got %0d", e.nrm_z, got.nrm_z); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  lbvs_req_if req_if ();
  lbvs_rsp_if rsp_if ();

  linear_blend_vertex_skinning_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  skin_scoreboard sb;
  bit loaded [VERTEX_DEPTH_DEF];
  bit calm;
  int sent;
  int reads;

  always #1 clk_i = ~clk_i;

  initial begin
    #4000000;
    $display("linear_blend_vertex_skinning_core test failed");
    $finish;
  end

  // Result side: random stalls before each word, none while calm is set.
  initial begin
    int n;
    rsp_if.ready = 1'b0;
    wait (rst_ni);
    forever begin
      n = calm ? 0 : $urandom_range(0, 7);
      if (n > 0) begin
        @(negedge clk_i) rsp_if.ready <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end
      @(negedge clk_i) rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
      sb.check(rsp_if.data);
    end
  end

  task automatic send(req_t r);
    int n;
    n = calm ? 0 : $urandom_range(0, 7);
    @(negedge clk_i);
    if (n > 0) begin
      req_if.valid <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data <= r;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note(r);
    sent++;
    if (r.req_type == REQ_READ) reads++;
  endtask

  // Writes vertex_count once the core is idle, then reads it back.
  task automatic set_vertex_count(int unsigned cnt);
    @(negedge clk_i) req_if.valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= cnt;
    @(negedge clk_i) penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i) begin
      pwrite <= 1'b0; penable <= 1'b0;
    end
    @(negedge clk_i) penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[CNT_W-1:0] !== CNT_W'(cnt)) begin
      $error("vertex_count: expected %0d, got %0d", cnt, prdata[CNT_W-1:0]);
      sb.errors++;
    end
    @(negedge clk_i) begin
      psel <= 1'b0; penable <= 1'b0;
    end
    sb.vertex_count = cnt;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2, 3: return $urandom();
      default: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
    endcase
  endfunction

  function automatic req_t make_req(req_type_e t, int idx, int row, int w);
    req_t r;
    r.req_type = t;
    r.vertex_index = IDX_W'(idx);
    r.matrix_row = 2'(row);
    r.val0 = pick_value(); r.val1 = pick_value();
    r.val2 = pick_value(); r.val3 = pick_value();
    r.norm_x = pick_value(); r.norm_y = pick_value(); r.norm_z = pick_value();
    r.weight = WGT_W'(w);
    return r;
  endfunction

  task automatic random_phase(int unsigned cnt, int items);
    req_t r;
    req_type_e t;
    int idx;
    int sel;
    int w;
    set_vertex_count(cnt);
    for (int k = 0; k < items; k++) begin
      if (k % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 99);
      t = sel < 20 ? REQ_LOAD : sel < 45 ? REQ_MATRIX : sel < 80 ? REQ_WEIGHT : REQ_READ;
      if ($urandom_range(0, 4) == 0 || cnt == 0) idx = $urandom_range(0, 4095);
      else idx = $urandom_range(0, 7) % (cnt > 4096 ? 4096 : cnt);
      // Never touch a vertex in use that has not been loaded yet.
      if (t inside {REQ_WEIGHT, REQ_READ} && idx < cnt && !loaded[idx]) t = REQ_LOAD;
      if (t == REQ_LOAD && idx < cnt) loaded[idx] = 1'b1;
      sel = $urandom_range(0, 9);
      w = sel < 7 ? $urandom_range(0, 65536) : sel < 9 ? 65536 : $urandom_range(0, 131071);
      r = make_req(t, idx, $urandom_range(0, 3), w);
      send(r);
    end
  endtask

  initial begin
    req_t r;
    sb = new();
    sb.reset_state();
    calm = 1'b0;
    sent = 0;
    reads = 0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // No vertex in use: everything addressed is ignored, matrix items still apply.
    r = make_req(REQ_LOAD, 0, 0, 0); send(r);
    r = make_req(REQ_WEIGHT, 4095, 0, 65536); send(r);
    r = make_req(REQ_READ, 4095, 0, 0); send(r);
    r = make_req(REQ_MATRIX, 4095, 3, 0); send(r);
    r = make_req(REQ_MATRIX, 4095, 0, 131071); send(r);

    set_vertex_count(4096);
    r = make_req(REQ_LOAD, 4095, 0, 0);
    r.val0 = 32'h8000_0000; r.val1 = 32'h7fff_ffff; r.val2 = 32'h8000_0000;
    r.norm_x = 32'h7fff_ffff; r.norm_y = 32'h8000_0000; r.norm_z = 32'h7fff_ffff;
    send(r); loaded[4095] = 1'b1;
    r = make_req(REQ_LOAD, 0, 0, 0);
    r.norm_x = 0; r.norm_y = 0; r.norm_z = 0;
    send(r); loaded[0] = 1'b1;
    for (int row = 0; row < 3; row++) begin
      r = make_req(REQ_MATRIX, 0, row, 0);
      r.val0 = 32'h7fff_ffff; r.val1 = 32'h8000_0000;
      r.val2 = 32'h7fff_ffff; r.val3 = 32'h8000_0000;
      send(r);
    end
    r = make_req(REQ_MATRIX, 0, 3, 0); send(r);
    r = make_req(REQ_WEIGHT, 4095, 0, 131071); send(r);
    r = make_req(REQ_WEIGHT, 4095, 0, 65536); send(r);
    r = make_req(REQ_WEIGHT, 0, 0, 0); send(r);
    r = make_req(REQ_READ, 0, 0, 0); send(r);
    r = make_req(REQ_READ, 4095, 0, 0); send(r);
    r = make_req(REQ_LOAD, 2730, 0, 0); send(r); loaded[2730] = 1'b1;
    r = make_req(REQ_WEIGHT, 2730, 0, 1); send(r);
    r = make_req(REQ_READ, 2730, 0, 0); send(r);
    set_vertex_count(1);
    r = make_req(REQ_READ, 1, 0, 0); send(r);
    r = make_req(REQ_READ, 0, 0, 0); send(r);

    random_phase(4096, 300);
    random_phase(1, 150);
    random_phase(8191, 250);
    random_phase(37, 250);
    random_phase(0, 100);
    random_phase(200, 250);

    @(negedge clk_i) req_if.valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("Covered %0d requests (%0d reads, %0d results checked)", sent, reads, sb.checked);
    $display("over vertex counts 0, 1, 37, 200, 4096 and 8191.");
    if (sb.errors == 0 && sb.owed.size() == 0)
      $display("linear_blend_vertex_skinning_core test passed");
    else
      $display("linear_blend_vertex_skinning_core test failed");
    $finish;
  end
endmodule
`default_nettype wire
